@@ rtl/core/gdec_pkg.sv @@
`timescale 1ns / 1ps

package gdec_pkg;

    // field widths
    localparam int IDX_W      = 18;
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 6;
    localparam int STEP_W     = 3;

    // graph6 character constants
    localparam logic [BYTE_W-1:0] CHAR_BIAS = 8'd63;
    localparam logic [BYTE_W-1:0] LONG_MARK = 8'd126;
    localparam logic [1:0]        HDR_GROUPS = 2'd3;
    localparam logic [STEP_W-1:0] TOP_BIT   = 3'd5;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_COUNT = 2'd0,
        CMD_UNSUP = 2'd1,
        CMD_DATA  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_UNSUP = 2'd2
    } t_kind;

    // one queue entry: count for CMD_COUNT, six data bits for CMD_DATA
    typedef struct packed {
        t_cmd             kind;
        logic [IDX_W-1:0] val;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_push;

endpackage

@@ rtl/core/gdec_front.sv @@
`timescale 1ns / 1ps

module gdec_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gdec_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_start,
    input  logic                         i_full,
    output gdec_pkg::t_push              o_push
);

    gdec_pkg::t_phase             r_phase, n_phase;
    logic [1:0]                   r_left, n_left;
    logic [gdec_pkg::IDX_W-1:0]   r_count, n_count;

    logic                         accept;
    logic [gdec_pkg::BYTE_W-1:0]  diff;
    logic [gdec_pkg::GROUP_W-1:0] six;
    logic [gdec_pkg::IDX_W-1:0]   shifted;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign diff    = i_byte - gdec_pkg::CHAR_BIAS;
    assign six     = diff[gdec_pkg::GROUP_W-1:0];
    assign shifted = {r_count[gdec_pkg::IDX_W-gdec_pkg::GROUP_W-1:0], six};

    // header parse and byte classification
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_count = r_count;
        o_push.valid    = 1'b0;
        o_push.ent.kind = gdec_pkg::CMD_DATA;
        o_push.ent.val  = '0;
        if (accept) begin
            if (i_start) begin
                if (i_byte < gdec_pkg::LONG_MARK) begin
                    n_phase = gdec_pkg::PH_DATA;
                    n_count = {{(gdec_pkg::IDX_W-gdec_pkg::GROUP_W){1'b0}}, six};
                    o_push.valid    = 1'b1;
                    o_push.ent.kind = gdec_pkg::CMD_COUNT;
                    o_push.ent.val  = n_count;
                end else if (i_byte == gdec_pkg::LONG_MARK) begin
                    n_phase = gdec_pkg::PH_HEAD;
                    n_left  = gdec_pkg::HDR_GROUPS;
                    n_count = '0;
                end else begin
                    n_phase = gdec_pkg::PH_IDLE;
                    n_left  = 2'd0;
                    n_count = '0;
                    o_push.valid    = 1'b1;
                    o_push.ent.kind = gdec_pkg::CMD_UNSUP;
                end
            end else begin
                unique case (r_phase)
                    gdec_pkg::PH_HEAD: begin
                        if (r_left == gdec_pkg::HDR_GROUPS && i_byte >= gdec_pkg::LONG_MARK) begin
                            // long form beyond 18 bits
                            n_phase = gdec_pkg::PH_IDLE;
                            n_left  = 2'd0;
                            n_count = '0;
                            o_push.valid    = 1'b1;
                            o_push.ent.kind = gdec_pkg::CMD_UNSUP;
                        end else begin
                            n_count = shifted;
                            n_left  = r_left - 2'd1;
                            if (r_left == 2'd1) begin
                                n_phase = gdec_pkg::PH_DATA;
                                o_push.valid    = 1'b1;
                                o_push.ent.kind = gdec_pkg::CMD_COUNT;
                                o_push.ent.val  = shifted;
                            end
                        end
                    end
                    gdec_pkg::PH_DATA: begin
                        o_push.valid   = 1'b1;
                        o_push.ent.val = {{(gdec_pkg::IDX_W-gdec_pkg::GROUP_W){1'b0}}, six};
                    end
                    default: begin
                        // idle: byte dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gdec_pkg::PH_IDLE;
            r_left  <= 2'd0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/core/gdec_fifo.sv @@
`timescale 1ns / 1ps

module gdec_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gdec_pkg::t_push i_push,
    output logic            o_full,
    output logic            o_valid,
    output gdec_pkg::t_qent o_ent,
    input  logic            i_pop
);

    gdec_pkg::t_qent              r_mem [gdec_pkg::Q_DEPTH];
    logic [gdec_pkg::Q_AW-1:0]    r_wp, r_rp;
    logic [gdec_pkg::Q_CW-1:0]    r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == gdec_pkg::Q_CW'(gdec_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/gdec_back.sv @@
`timescale 1ns / 1ps

module gdec_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  gdec_pkg::t_qent             i_q_ent,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output gdec_pkg::t_kind             o_kind,
    output logic [gdec_pkg::IDX_W-1:0]  o_cnt,
    output logic [gdec_pkg::IDX_W-1:0]  o_row,
    output logic [gdec_pkg::IDX_W-1:0]  o_col,
    output logic                        o_last
);

    localparam int W = gdec_pkg::IDX_W;

    // pair walk state
    logic [W-1:0]                  r_row, n_row;
    logic [W-1:0]                  r_col, n_col;
    logic [W-1:0]                  r_cnt, n_cnt;
    logic [gdec_pkg::STEP_W-1:0]   r_step, n_step;

    // one held edge; done marks it as the final result of its byte
    logic                          r_pv, n_pv;
    logic                          r_pdone, n_pdone;
    logic [W-1:0]                  r_prow, n_prow;
    logic [W-1:0]                  r_pcol, n_pcol;

    // output register
    logic                          r_ov;
    gdec_pkg::t_kind               r_okind;
    logic [W-1:0]                  r_ocnt, r_orow, r_ocol;
    logic                          r_olast;

    logic                          out_free;
    logic                          emit;
    gdec_pkg::t_kind               e_kind;
    logic [W-1:0]                  e_cnt, e_row, e_col;
    logic                          e_last;

    logic [gdec_pkg::GROUP_W-1:0]  bits;
    logic                          bit_set;
    logic                          in_range;
    logic [W-1:0]                  col_inc, row_inc, row_next, col_next;
    logic                          final_step;

    assign out_free   = !r_ov || i_ready;
    assign bits       = i_q_ent.val[gdec_pkg::GROUP_W-1:0];
    assign bit_set    = bits[r_step];
    assign in_range   = r_row < r_cnt;
    assign col_inc    = r_col + 1'b1;
    assign row_inc    = r_row + 1'b1;
    assign row_next   = (col_inc == r_row) ? row_inc : r_row;
    assign col_next   = (col_inc == r_row) ? '0 : col_inc;
    assign final_step = (r_step == '0) || (row_next >= r_cnt);

    // one bit of the current byte per cycle, stalling while a held edge meets a busy output
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_pv    = r_pv;
        n_pdone = r_pdone;
        n_prow  = r_prow;
        n_pcol  = r_pcol;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        e_kind  = gdec_pkg::KIND_EDGE;
        e_cnt   = r_cnt;
        e_row   = r_prow;
        e_col   = r_pcol;
        e_last  = 1'b1;
        if (i_q_valid) begin
            unique case (i_q_ent.kind)
                gdec_pkg::CMD_DATA: begin
                    if (!in_range) begin
                        // trailing byte past the last pair
                        o_q_pop = 1'b1;
                        n_step  = gdec_pkg::TOP_BIT;
                        if (r_pv && r_pdone && out_free) begin
                            emit = 1'b1;
                            n_pv = 1'b0;
                        end
                    end else if (!(bit_set && r_pv && !out_free)) begin
                        n_row = row_next;
                        n_col = col_next;
                        if (bit_set) begin
                            if (r_pv) begin
                                emit   = 1'b1;
                                e_last = r_pdone;
                            end
                            n_pv    = 1'b1;
                            n_prow  = r_row;
                            n_pcol  = r_col;
                            n_pdone = final_step;
                        end else if (r_pv) begin
                            if (r_pdone && out_free) begin
                                emit = 1'b1;
                                n_pv = 1'b0;
                            end else if (final_step) begin
                                n_pdone = 1'b1;
                            end
                        end
                        if (final_step) begin
                            o_q_pop = 1'b1;
                            n_step  = gdec_pkg::TOP_BIT;
                        end else begin
                            n_step = r_step - 1'b1;
                        end
                    end
                end
                gdec_pkg::CMD_COUNT, gdec_pkg::CMD_UNSUP: begin
                    if (r_pv) begin
                        // drain the held edge first
                        if (out_free) begin
                            emit = 1'b1;
                            n_pv = 1'b0;
                        end
                    end else if (out_free) begin
                        emit    = 1'b1;
                        o_q_pop = 1'b1;
                        e_row   = '0;
                        e_col   = '0;
                        n_step  = gdec_pkg::TOP_BIT;
                        if (i_q_ent.kind == gdec_pkg::CMD_COUNT) begin
                            e_kind = gdec_pkg::KIND_COUNT;
                            e_cnt  = i_q_ent.val;
                            n_cnt  = i_q_ent.val;
                            n_row  = W'(1);
                            n_col  = '0;
                        end else begin
                            e_kind = gdec_pkg::KIND_UNSUP;
                            e_cnt  = '0;
                            n_cnt  = '0;
                        end
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end else if (r_pv && r_pdone && out_free) begin
            emit = 1'b1;
            n_pv = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= W'(1);
            r_col   <= '0;
            r_cnt   <= '0;
            r_step  <= gdec_pkg::TOP_BIT;
            r_pv    <= 1'b0;
            r_pdone <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_pv    <= n_pv;
            r_pdone <= n_pdone;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prow <= n_prow;
        r_pcol <= n_pcol;
        if (emit) begin
            r_okind <= e_kind;
            r_ocnt  <= e_cnt;
            r_orow  <= e_row;
            r_ocol  <= e_col;
            r_olast <= e_last;
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_okind;
    assign o_cnt   = r_ocnt;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_last  = r_olast;

    // a held edge that is not final belongs to the byte at the queue head
    a_pend_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && !r_pdone) |-> (i_q_valid && i_q_ent.kind == gdec_pkg::CMD_DATA))
        else $error("held edge without its byte");

    // walk stays in the lower triangle
    a_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < r_row)
        else $error("pair column not below row");

    // emitted edges lie inside the graph
    a_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_okind == gdec_pkg::KIND_EDGE) |-> (r_orow > r_ocol && r_orow < r_ocnt))
        else $error("edge outside graph");

    // a held edge is always a valid pair
    a_pend_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_prow < r_cnt))
        else $error("held edge out of range");

endmodule

@@ rtl/core/graph6_adjacency_decoder.sv @@
`timescale 1ns / 1ps
// Path: a header result passes the queue storage, then the output register; an edge
//   is held until the next set bit or the end of its byte. A 4-item queue decouples
//   intake from output. Throughput: one data bit per cycle, stalled when a held edge
//   meets a busy output; header bytes one per cycle while the queue has room.
// Reset: synchronous, active low; clears the parser, queue and walk state at once.
module graph6_adjacency_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tuser,   // [0] start_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [17:0] vertex_count, [35:18] row, [53:36] col
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast
);

    gdec_pkg::t_push               push;
    logic                          q_full, q_valid, q_pop;
    gdec_pkg::t_qent               q_ent;
    gdec_pkg::t_kind               kind;
    logic [gdec_pkg::IDX_W-1:0]    cnt, row, col;

    gdec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .i_full  (q_full),
        .o_push  (push)
    );

    gdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (q_pop)
    );

    gdec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (kind),
        .o_cnt     (cnt),
        .o_row     (row),
        .o_col     (col),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, col, row, cnt};
    assign o_m_axis_tuser = kind;

endmodule
